@@ hdl/block_majority_decimator_3x3_defines.svh @@
// ----------------------------------------------------------------------------
// block majority decimator 3x3 assertion macros
// shared property wrappers, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BLOCK_MAJORITY_DECIMATOR_3X3_DEFINES_SVH
`define BLOCK_MAJORITY_DECIMATOR_3X3_DEFINES_SVH

// same-cycle implication
`define BMD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmd assertion failed");

// next-cycle implication
`define BMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmd assertion failed");

`endif

@@ hdl/bmd_pkg.sv @@
// ----------------------------------------------------------------------------
// bmd_pkg
// constants, types and helpers of the 3x3 majority decimator
// ----------------------------------------------------------------------------
package bmd_pkg;

  localparam int TILE        = 3;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int VALUE_BITS  = 8;
  localparam int SUM_BITS    = 12;
  localparam int SUM_DEPTH   = MAX_WIDTH / TILE;
  localparam int ADDR_BITS   = $clog2(SUM_DEPTH);

  localparam int WIDTH_BITS  = 11;  // lattice_width register
  localparam int HEIGHT_BITS = 13;  // lattice_height register
  localparam int CFG_BITS    = 13;
  localparam int COL_BITS    = 10;
  localparam int ROW_BITS    = 12;
  localparam int TCOL_BITS   = 9;
  localparam int TROW_BITS   = 11;
  localparam int PHASE_BITS  = 2;

  typedef logic signed [VALUE_BITS-1:0] site_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic [ADDR_BITS-1:0]         addr_t;
  typedef logic [PHASE_BITS-1:0]        phase_t;

  // register indexes
  typedef enum logic {
    CFG_LATTICE_WIDTH  = 1'b0,
    CFG_LATTICE_HEIGHT = 1'b1
  } cfg_index_t;

  localparam logic signed [1:0] BLOCK_POS = 2'sb01;
  localparam logic signed [1:0] BLOCK_NEG = 2'sb11;

  localparam phase_t PHASE_LAST = phase_t'(TILE - 1);

  localparam logic [WIDTH_BITS-1:0]  WIDTH_MIN  = WIDTH_BITS'(TILE);
  localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX  = WIDTH_BITS'(MAX_WIDTH);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN = HEIGHT_BITS'(TILE);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX = HEIGHT_BITS'(MAX_HEIGHT);
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(512);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(512);

  // saturating add of a partial sum and one site
  function automatic sum_t sat_add(sum_t a, site_t b);
    logic signed [SUM_BITS:0] s;
    s = SUM_BITS'(0) + $signed({a[SUM_BITS-1], a}) + (SUM_BITS+1)'(b);
    if (s > $signed({1'b0, 1'b0, {(SUM_BITS-1){1'b1}}}))
      return {1'b0, {(SUM_BITS-1){1'b1}}};
    else if (s < $signed({1'b1, 1'b1, {(SUM_BITS-1){1'b0}}}))
      return {1'b1, {(SUM_BITS-1){1'b0}}};
    else
      return s[SUM_BITS-1:0];
  endfunction

endpackage

@@ hdl/bmd_ram.sv @@
// ----------------------------------------------------------------------------
// bmd_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/block_majority_decimator_3x3.sv @@
// a block word reaches the output through stage 1 and the output register after the site that closes its tile
// throughput: one site per cycle unless stalled; sums live in one ram, read on accept, written back from stage 1
// input stalls only while a block is ready in stage 1 and the output register holds one that is not taken
// reset: synchronous, clears counters, pipeline and output valid, loads 512 x 512
// tile sum ram has no reset; each tile writes its sum first at its top-left site
// ----------------------------------------------------------------------------
// block_majority_decimator_3x3
// 3x3 block-spin majority decimation of a raster-order site stream
// ----------------------------------------------------------------------------
`include "block_majority_decimator_3x3_defines.svh"

module block_majority_decimator_3x3 (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [bmd_pkg::CFG_BITS-1:0]  cfg_data,
  // site stream
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [bmd_pkg::VALUE_BITS-1:0] site_value,
  // block stream
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [1:0]             block_value,
  output logic [bmd_pkg::TCOL_BITS-1:0] block_col,
  output logic [bmd_pkg::TROW_BITS-1:0] block_row,
  output logic                          frame_last
);

  import bmd_pkg::*;

  // --------------------------------------------------------------------------
  // configuration, clamped on write to the legal range
  // --------------------------------------------------------------------------
  logic [WIDTH_BITS-1:0]  width_eff;
  logic [HEIGHT_BITS-1:0] height_eff;
  logic [WIDTH_BITS-1:0]  cfg_w;
  logic [HEIGHT_BITS-1:0] cfg_h;

  assign cfg_w = cfg_data[WIDTH_BITS-1:0];
  assign cfg_h = cfg_data[HEIGHT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WIDTH_RESET;
      height_eff <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_LATTICE_WIDTH: begin
          width_eff <= (cfg_w < WIDTH_MIN) ? WIDTH_MIN :
                       (cfg_w > WIDTH_MAX) ? WIDTH_MAX : cfg_w;
        end
        CFG_LATTICE_HEIGHT: begin
          height_eff <= (cfg_h < HEIGHT_MIN) ? HEIGHT_MIN :
                        (cfg_h > HEIGHT_MAX) ? HEIGHT_MAX : cfg_h;
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: position counters, tile decode, ram read
  // --------------------------------------------------------------------------
  logic [COL_BITS-1:0]  col_count;
  logic [ROW_BITS-1:0]  row_count;
  phase_t               col_phase;
  phase_t               row_phase;
  logic [TCOL_BITS-1:0] col_tile;
  logic [TROW_BITS-1:0] row_tile;

  logic                 accept;
  logic                 stall;
  logic [WIDTH_BITS:0]  col_base;   // first column of the current tile
  logic [HEIGHT_BITS:0] row_base;   // first row of the current tile
  logic                 fits_x, fits_y, last_x, last_y;
  logic                 in_tile, tile_start, tile_end;
  logic [WIDTH_BITS-1:0]  col_inc;
  logic [HEIGHT_BITS-1:0] row_inc;

  assign accept = in_valid && in_ready;

  // phase equals count mod 3, so count minus phase is the tile origin
  assign col_base = (WIDTH_BITS+1)'(col_count) - (WIDTH_BITS+1)'(col_phase);
  assign row_base = (HEIGHT_BITS+1)'(row_count) - (HEIGHT_BITS+1)'(row_phase);

  // whole tile fits when origin + 3 <= size; last tile when the next one would not
  assign fits_x = (col_base + (WIDTH_BITS+1)'(TILE)) <= (WIDTH_BITS+1)'(width_eff);
  assign fits_y = (row_base + (HEIGHT_BITS+1)'(TILE)) <= (HEIGHT_BITS+1)'(height_eff);
  assign last_x = (col_base + (WIDTH_BITS+1)'(2*TILE)) > (WIDTH_BITS+1)'(width_eff);
  assign last_y = (row_base + (HEIGHT_BITS+1)'(2*TILE)) > (HEIGHT_BITS+1)'(height_eff);

  assign in_tile    = fits_x && fits_y;
  assign tile_start = (col_phase == '0) && (row_phase == '0);
  assign tile_end   = (col_phase == PHASE_LAST) && (row_phase == PHASE_LAST);

  assign col_inc = WIDTH_BITS'(col_count) + WIDTH_BITS'(1);
  assign row_inc = HEIGHT_BITS'(row_count) + HEIGHT_BITS'(1);

  // raster walk; a counter past a shrunk size wraps on its next advance
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      col_phase <= '0;
      row_phase <= '0;
      col_tile  <= '0;
      row_tile  <= '0;
    end else if (accept) begin
      if (col_inc >= width_eff) begin
        col_count <= '0;
        col_phase <= '0;
        col_tile  <= '0;
        if (row_inc >= height_eff) begin
          row_count <= '0;
          row_phase <= '0;
          row_tile  <= '0;
        end else begin
          row_count <= row_inc[ROW_BITS-1:0];
          if (row_phase == PHASE_LAST) begin
            row_phase <= '0;
            row_tile  <= row_tile + TROW_BITS'(1);
          end else begin
            row_phase <= row_phase + PHASE_BITS'(1);
          end
        end
      end else begin
        col_count <= col_inc[COL_BITS-1:0];
        if (col_phase == PHASE_LAST) begin
          col_phase <= '0;
          col_tile  <= col_tile + TCOL_BITS'(1);
        end else begin
          col_phase <= col_phase + PHASE_BITS'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // tile sum ram: read at accept, written back from stage 1
  // --------------------------------------------------------------------------
  logic  ram_re;
  logic  ram_we;
  addr_t rd_addr;
  sum_t  rd_data;
  sum_t  s1_sum;
  addr_t s1_addr;

  assign ram_re  = accept && in_tile;
  assign rd_addr = col_tile[ADDR_BITS-1:0];

  bmd_ram #(
    .WIDTH (SUM_BITS),
    .DEPTH (SUM_DEPTH)
  ) u_sum_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (s1_sum),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // --------------------------------------------------------------------------
  // stage 1: accumulate, saturate, write back, form the block word
  // --------------------------------------------------------------------------
  logic                 s1_valid;
  logic                 s1_start;
  logic                 s1_emit;
  logic                 s1_last;
  site_t                s1_value;
  logic [TCOL_BITS-1:0] s1_col;
  logic [TROW_BITS-1:0] s1_row;
  logic                 s1_fire;
  logic                 fwd_hit;    // read raced the write-back of the same entry
  sum_t                 fwd_data;
  sum_t                 s1_base;

  // hold stage 1 only when its block has nowhere to go
  assign stall    = s1_valid && s1_emit && out_valid && !out_ready;
  assign in_ready = !stall;
  assign s1_fire  = s1_valid && !stall;
  assign ram_we   = s1_fire;

  assign s1_base = fwd_hit ? fwd_data : rd_data;
  assign s1_sum  = s1_start ? SUM_BITS'(s1_value) : sat_add(s1_base, s1_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= in_tile;
        fwd_hit  <= s1_fire && in_tile && (s1_addr == rd_addr);
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
        fwd_hit  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_start <= tile_start;
      s1_emit  <= tile_end;
      s1_last  <= last_x && last_y;
      s1_value <= site_value;
      s1_addr  <= rd_addr;
      s1_col   <= col_tile;
      s1_row   <= row_tile;
      fwd_data <= s1_sum;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit) begin
      block_value <= (s1_sum > 0) ? BLOCK_POS : BLOCK_NEG;
      block_col   <= s1_col;
      block_row   <= s1_row;
      frame_last  <= s1_last;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a blocked tile end keeps its place in stage 1
  `BMD_ASSERT_NEXT(a_stall_holds, stall, s1_valid && s1_emit)
  // forwarding only ever serves a live stage 1 item
  `BMD_ASSERT_NOW(a_fwd_live, fwd_hit, s1_valid)
  // phases stay within one tile
  `BMD_ASSERT_NOW(a_phase_range, 1'b1, (col_phase != 2'd3) && (row_phase != 2'd3))

endmodule

@@ test/block_majority_checker.sv @@
// ----------------------------------------------------------------------------
// block majority checker
// watches the site and block streams of the 3x3 majority decimator, keeps its
// own tile sums and raster counters, and compares every block word in order
// ----------------------------------------------------------------------------
module block_majority_checker
  import bmd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [CFG_BITS-1:0]           cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [VALUE_BITS-1:0]  site_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [1:0]             block_value,
  input  logic [TCOL_BITS-1:0]          block_col,
  input  logic [TROW_BITS-1:0]          block_row,
  input  logic                          frame_last,
  output int                            fail_count,
  output int                            pending
);

  localparam int SUM_HI = 2 ** (SUM_BITS - 1) - 1;
  localparam int SUM_LO = -(2 ** (SUM_BITS - 1));

  typedef struct packed {
    logic [1:0]           value;
    logic [TCOL_BITS-1:0] col;
    logic [TROW_BITS-1:0] row;
    logic                 last;
  } block_word_t;

  block_word_t           expected_blocks[$];
  sum_t                  tile_sum [SUM_DEPTH];
  logic [WIDTH_BITS-1:0] width_reg;
  logic [HEIGHT_BITS-1:0] height_reg;
  int unsigned           col_pos, row_pos, col_ph, row_ph;

  // one site into the running tile sums; queues a block word on a tile's last site
  function automatic void fold_site(input site_t v);
    int unsigned w, h, tiles_x, tiles_y, ti, tj;
    int          acc;
    block_word_t blk;
    w = (width_reg < TILE) ? TILE : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg < TILE) ? TILE : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    tiles_x = w / TILE;
    tiles_y = h / TILE;
    if (col_pos < tiles_x * TILE && row_pos < tiles_y * TILE) begin
      ti = col_pos / TILE;
      tj = row_pos / TILE;
      if (col_ph == 0 && row_ph == 0)
        acc = int'(v);
      else
        acc = int'(tile_sum[ti]) + int'(v);
      if (acc > SUM_HI)
        acc = SUM_HI;
      else if (acc < SUM_LO)
        acc = SUM_LO;
      tile_sum[ti] = sum_t'(acc);
      if (col_ph == TILE - 1 && row_ph == TILE - 1) begin
        blk.value = (acc > 0) ? BLOCK_POS : BLOCK_NEG;
        blk.col   = TCOL_BITS'(ti);
        blk.row   = TROW_BITS'(tj);
        blk.last  = (ti == tiles_x - 1) && (tj == tiles_y - 1);
        expected_blocks.push_back(blk);
      end
    end
    col_pos++;
    col_ph = (col_ph == TILE - 1) ? 0 : col_ph + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      col_ph  = 0;
      row_pos++;
      row_ph = (row_ph == TILE - 1) ? 0 : row_ph + 1;
      if (row_pos >= h) begin
        row_pos = 0;
        row_ph  = 0;
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    block_word_t want;
    int          bad;
    bad = 0;
    if (rst) begin
      expected_blocks.delete();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      col_pos = 0;
      row_pos = 0;
      col_ph  = 0;
      row_ph  = 0;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LATTICE_WIDTH)
          width_reg = cfg_data[WIDTH_BITS-1:0];
        else
          height_reg = cfg_data[HEIGHT_BITS-1:0];
      end
      if (in_valid && in_ready)
        fold_site(site_value);
      if (out_valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          $error("unexpected block word: value %0d col %0d row %0d last %0b",
                 block_value, block_col, block_row, frame_last);
          bad++;
        end else begin
          want = expected_blocks.pop_front();
          if (block_value !== want.value) begin
            $error("block_value: expected %0d, got %0d", $signed(want.value), block_value);
            bad++;
          end
          if (block_col !== want.col) begin
            $error("block_col: expected %0d, got %0d", want.col, block_col);
            bad++;
          end
          if (block_row !== want.row) begin
            $error("block_row: expected %0d, got %0d", want.row, block_row);
            bad++;
          end
          if (frame_last !== want.last) begin
            $error("frame_last: expected %0b, got %0b", want.last, frame_last);
            bad++;
          end
        end
      end
      fail_count <= fail_count + bad;
    end
    pending <= expected_blocks.size();
  end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// site stream stimulus for the 3x3 majority decimator: directed tiles, mid
// frame size changes, one wide frame without idling and random lattices, with
// random idling on both sides; checking is done by block_majority_checker
// ----------------------------------------------------------------------------
module tb_top;
  import bmd_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 4;        // idle time after the last owed block word
  localparam int HOLD_CYCLES   = 300;      // long receiver hold-off
  localparam int RANDOM_SITES  = 400;
  localparam int WIDE_WIDTH    = 150;      // width of the frame streamed without idling
  localparam int RUN_LIMIT     = 2000000;  // time units, far above the slowest clean run

  typedef enum int { FILL_SPINS, FILL_TERNARY, FILL_RAW } fill_t;

  // clock, reset and block inputs, all known from time zero
  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   cfg_we     = 1'b0;
  logic                   cfg_index  = 1'b0;
  logic [CFG_BITS-1:0]    cfg_data   = '0;
  logic                   in_valid   = 1'b0;
  site_t                  site_value = '0;
  logic                   out_ready  = 1'b0;

  logic                   in_ready;
  logic                   out_valid;
  logic signed [1:0]      block_value;
  logic [TCOL_BITS-1:0]   block_col;
  logic [TROW_BITS-1:0]   block_row;
  logic                   frame_last;

  int                     fail_count;
  int                     pending;      // block words still owed by the block

  bit                     calm     = 1'b0;  // no idling on either side while set
  bit                     hold_req = 1'b0;  // asks the receiver for one long hold-off

  always #HALF_PERIOD clk = ~clk;

  block_majority_decimator_3x3 dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .site_value  (site_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .block_value (block_value),
    .block_col   (block_col),
    .block_row   (block_row),
    .frame_last  (frame_last)
  );

  block_majority_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .site_value  (site_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .block_value (block_value),
    .block_col   (block_col),
    .block_row   (block_row),
    .frame_last  (frame_last),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // one site word: random idle cycles first, then hold valid until accepted
  task automatic send_site(input site_t v);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    site_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid, wait for every owed block word, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_lattice(input int unsigned w, input int unsigned h);
    drain();
    write_reg(CFG_LATTICE_WIDTH, CFG_BITS'(w));
    write_reg(CFG_LATTICE_HEIGHT, CFG_BITS'(h));
  endtask

  function automatic site_t pick_site(input fill_t fill);
    case (fill)
      FILL_RAW:     return site_t'($urandom_range(255));
      FILL_TERNARY: return site_t'(int'($urandom_range(2)) - 1);
      default: begin
        // mostly clean spins, a little full-range noise
        if ($urandom_range(99) < 6)
          return site_t'($urandom_range(255));
        return $urandom_range(1) ? site_t'(1) : site_t'(-1);
      end
    endcase
  endfunction

  task automatic stream_sites(input int n, input fill_t fill);
    repeat (n) send_site(pick_site(fill));
  endtask

  // raw register value: mostly typical, sometimes below the minimum, sometimes larger
  function automatic int unsigned pick_extent(input int unsigned typ_hi,
                                              input int unsigned big_hi);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10)
      return $urandom_range(2);
    if (r < 20)
      return $urandom_range(big_hi, typ_hi + 1);
    return $urandom_range(typ_hi, TILE);
  endfunction

  // receiver: random stalls, none while calm, one long hold-off on request
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 14);
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned w_raw, h_raw, w, h, frames, random_sites;
    fill_t       fill;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // smallest lattice: an all-zero tile is a tie and must give -1
    set_lattice(3, 3);
    repeat (9) send_site(site_t'(0));

    // extremes of the site value, plus one ignored column of raw noise
    set_lattice(4, 3);
    for (int k = 0; k < 12; k++) begin
      if (k % 4 == 3)
        send_site(pick_site(FILL_RAW));
      else
        send_site((k % 2 == 0) ? site_t'(127) : site_t'(-128));
    end

    // narrow tall lattice with the receiver holding off, so the input backs up
    set_lattice(3, 30);
    hold_req = 1'b1;
    stream_sites(90, FILL_SPINS);

    // width shrunk mid-frame: the tile row was opened at the wider width, and
    // the column counter sits past the new width so it wraps on its next step
    set_lattice(12, 9);
    stream_sites(58, FILL_SPINS);
    drain();
    write_reg(CFG_LATTICE_WIDTH, CFG_BITS'(7));
    stream_sites(29, FILL_RAW);

    // height above the maximum clamps, then shrinks under the row counter
    set_lattice(3, 8191);
    stream_sites(90, FILL_TERNARY);
    drain();
    write_reg(CFG_LATTICE_HEIGHT, CFG_BITS'(5));
    stream_sites(3, FILL_RAW);

    // one wide frame in one stretch without idling
    set_lattice(WIDE_WIDTH, 3);
    calm = 1'b1;
    stream_sites(WIDE_WIDTH * TILE, FILL_SPINS);
    drain();
    calm = 1'b0;

    // random lattices, whole frames each so every tile opens at its top-left site
    random_sites = 0;
    for (int p = 0; random_sites < RANDOM_SITES; p++) begin
      w_raw  = pick_extent(13, 24);
      h_raw  = pick_extent(12, 18);
      w      = (w_raw < TILE) ? TILE : w_raw;
      h      = (h_raw < TILE) ? TILE : h_raw;
      frames = $urandom_range(2, 1);
      case ($urandom_range(9))
        0, 1:    fill = FILL_TERNARY;
        2, 3:    fill = FILL_RAW;
        default: fill = FILL_SPINS;
      endcase
      drain();
      // junk in the unused upper bits of the width write
      write_reg(CFG_LATTICE_WIDTH, {2'($urandom_range(3)), WIDTH_BITS'(w_raw)});
      write_reg(CFG_LATTICE_HEIGHT, CFG_BITS'(h_raw));
      for (int f = 0; f < frames; f++) begin
        for (int k = 0; k < w * h; k++) begin
          // once, mid-frame: sender pauses until every block word is out
          if (p == 0 && f == 0 && k == w * h / 2) begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (pending != 0) @(negedge clk);
          end
          send_site(pick_site(fill));
        end
      end
      random_sites += frames * w * h;
    end

    drain();
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // hard stop if the block hangs
  initial begin : watchdog
    #RUN_LIMIT;
    $display("Regression FAIL");
    $finish;
  end

endmodule
